/* hdl/btq_pkg.sv */
package btq_pkg;

  localparam int unsigned BIN_W = 10;
  localparam int unsigned THR_W = 6;
  localparam int unsigned RUN_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned HISTORY_BITS_DEF = 32;

  localparam logic [BIN_W-1:0] TARGET_A_RST = 10'd117;
  localparam logic [BIN_W-1:0] TARGET_B_RST = 10'd243;
  localparam logic WIDE_MATCH_RST = 1'b1;
  localparam logic [THR_W-1:0] LONG_MIN_RST = 6'd22;
  localparam logic [THR_W-1:0] SHORT_MIN_RST = 6'd2;
  localparam logic [RUN_W-1:0] RUN_LOW_RST = 16'd1;
  localparam logic [RUN_W-1:0] RUN_HIGH_RST = 16'd35;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_A  = 3'd0,
    REG_TARGET_B  = 3'd1,
    REG_WIDE      = 3'd2,
    REG_LONG_MIN  = 3'd3,
    REG_SHORT_MIN = 3'd4,
    REG_RUN_LOW   = 3'd5,
    REG_RUN_HIGH  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [BIN_W-1:0] target_a;
    logic [BIN_W-1:0] target_b;
    logic             wide;
  } match_cfg_t;

endpackage

/* hdl/btq_match.sv */
module btq_match (
  input  btq_pkg::match_cfg_t             cfg,
  input  logic [btq_pkg::BIN_W-1:0]       peak_bin,
  output logic                            hit
);
  import btq_pkg::*;

  logic near_a;
  logic near_b;

  // adjacency taken one bit wider so the edges never wrap
  function automatic logic near(input logic [BIN_W-1:0] peak,
                                input logic [BIN_W-1:0] tgt,
                                input logic wide);
    logic [BIN_W:0] p;
    logic [BIN_W:0] t;
    begin
      p = {1'b0, peak};
      t = {1'b0, tgt};
      near = (peak == tgt) ||
             (wide && ((p == t + (BIN_W+1)'(1)) || (p + (BIN_W+1)'(1) == t)));
    end
  endfunction

  assign near_a = near(peak_bin, cfg.target_a, cfg.wide);
  assign near_b = near(peak_bin, cfg.target_b, cfg.wide);
  assign hit = near_a | near_b;

endmodule

/* hdl/beep_tone_hit_qualifier.sv */
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------
// in       | in_valid / in_stall        | peak_bin
// out      | out_valid / out_stall      | short_beep, long_tone, short_tone
// config   | cfg_we, cfg_index          | cfg_data
//
// one item per cycle unless in_stall holds it; each result is registered
// history, its running popcount and the run counter update in the accept cycle
// a two-entry output buffer takes one more item while a result is held;
// in_stall rises only when both entries are full
// rst clears state, the valid flags and loads the register defaults
module beep_tone_hit_qualifier #(
  parameter int unsigned HISTORY_BITS = btq_pkg::HISTORY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [btq_pkg::BIN_W-1:0]         peak_bin,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              short_beep,
  output logic                              long_tone,
  output logic                              short_tone,
  input  logic                              cfg_we,
  input  logic [btq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btq_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import btq_pkg::*;

  localparam int unsigned POP_W = $clog2(HISTORY_BITS + 1);
  localparam int unsigned CMP_W = (POP_W > THR_W) ? POP_W : THR_W;

  match_cfg_t       match_cfg;
  logic [THR_W-1:0] long_hit_min;
  logic [THR_W-1:0] short_hit_min;
  logic [RUN_W-1:0] run_low_limit;
  logic [RUN_W-1:0] run_high_limit;

  logic [HISTORY_BITS-1:0] hit_history;
  logic [POP_W-1:0]        pop_count;
  logic [RUN_W-1:0]        run_count;

  logic [HISTORY_BITS-1:0] hit_history_next;
  logic [POP_W-1:0]        pop_first;
  logic [POP_W-1:0]        pop_second;
  logic [RUN_W-1:0]        run_count_next;

  logic hit;
  logic accept;
  logic take;
  logic res_beep;
  logic res_long;
  logic res_short;

  logic       skid_valid;
  logic [2:0] skid_res;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      match_cfg.target_a <= TARGET_A_RST;
      match_cfg.target_b <= TARGET_B_RST;
      match_cfg.wide     <= WIDE_MATCH_RST;
      long_hit_min       <= LONG_MIN_RST;
      short_hit_min      <= SHORT_MIN_RST;
      run_low_limit      <= RUN_LOW_RST;
      run_high_limit     <= RUN_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_A:  match_cfg.target_a <= cfg_data[BIN_W-1:0];
        REG_TARGET_B:  match_cfg.target_b <= cfg_data[BIN_W-1:0];
        REG_WIDE:      match_cfg.wide <= cfg_data[0];
        REG_LONG_MIN:  long_hit_min <= cfg_data[THR_W-1:0];
        REG_SHORT_MIN: short_hit_min <= cfg_data[THR_W-1:0];
        REG_RUN_LOW:   run_low_limit <= cfg_data[RUN_W-1:0];
        REG_RUN_HIGH:  run_high_limit <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  btq_match u_match (
    .cfg      (match_cfg),
    .peak_bin (peak_bin),
    .hit      (hit)
  );

  assign accept = in_valid && !in_stall;
  assign take   = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // popcount tracked incrementally: add the new bit twice, drop the two shifted out
  always_comb begin
    pop_first  = pop_count - POP_W'(hit_history[HISTORY_BITS-1]) + POP_W'(hit);
    pop_second = pop_first - POP_W'(hit_history[HISTORY_BITS-2]) + POP_W'(hit);
    hit_history_next = {hit_history[HISTORY_BITS-3:0], hit, hit};

    res_long  = CMP_W'(pop_first) >= CMP_W'(long_hit_min);
    res_short = CMP_W'(pop_second) >= CMP_W'(short_hit_min);
    res_beep  = 1'b0;

    if (!res_short && (run_count > run_low_limit) && (run_count < run_high_limit)) begin
      res_beep = 1'b1;
      run_count_next = '0;
    end else if (res_long) begin
      run_count_next = run_count;
    end else if (res_short) begin
      run_count_next = (run_count == {RUN_W{1'b1}}) ? run_count : run_count + RUN_W'(1);
    end else begin
      run_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_history <= '0;
      pop_count   <= '0;
      run_count   <= '0;
    end else if (accept) begin
      hit_history <= hit_history_next;
      pop_count   <= pop_second;
      run_count   <= run_count_next;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      if (skid_valid) begin
        {short_beep, long_tone, short_tone} <= skid_res;
      end else begin
        {short_beep, long_tone, short_tone} <= {res_beep, res_long, res_short};
      end
    end else if (accept) begin
      skid_res <= {res_beep, res_long, res_short};
    end
  end

  a_pop_tracks: assert property (@(posedge clk) disable iff (rst)
    32'(pop_count) == 32'($countones(hit_history)))
    else $error("popcount out of step with history");

  a_beep_needs_short_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(short_beep && short_tone))
    else $error("beep reported with short tone set");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full with empty output");

  a_beep_clears_run: assert property (@(posedge clk) disable iff (rst)
    accept && res_beep |=> run_count == '0)
    else $error("run count not cleared after beep");

endmodule

/* tb/btq_tone_check.sv */
module btq_tone_check
  import btq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [BIN_W-1:0]      peak_bin,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  short_beep,
  input  logic                  long_tone,
  input  logic                  short_tone,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic short_beep;
    logic long_tone;
    logic short_tone;
  } frame_flags_t;

  logic [BIN_W-1:0]            tgt_a;
  logic [BIN_W-1:0]            tgt_b;
  logic                        wide;
  logic [THR_W-1:0]            long_min;
  logic [THR_W-1:0]            short_min;
  logic [RUN_W-1:0]            run_lo;
  logic [RUN_W-1:0]            run_hi;
  logic [HISTORY_BITS_DEF-1:0] hit_bits;
  logic [RUN_W-1:0]            run_cnt;
  frame_flags_t                flags_due[$];
  frame_flags_t                got;
  frame_flags_t                want;

  // adjacency is a plain integer difference, no wrap at 0 or 1023
  function automatic bit near_bin(logic [BIN_W-1:0] bin, logic [BIN_W-1:0] tgt);
    int b;
    int t;
    b = bin;
    t = tgt;
    return (b == t) || (wide && (b == t + 1 || b + 1 == t));
  endfunction

  function automatic frame_flags_t qualify_frame(logic [BIN_W-1:0] bin);
    frame_flags_t f;
    logic         hit;
    hit = near_bin(bin, tgt_a) || near_bin(bin, tgt_b);
    hit_bits = {hit_bits[HISTORY_BITS_DEF-2:0], hit};
    f.long_tone = $countones(hit_bits) >= long_min;
    hit_bits = {hit_bits[HISTORY_BITS_DEF-2:0], hit};
    f.short_tone = $countones(hit_bits) >= short_min;
    f.short_beep = 1'b0;
    if (!f.short_tone && run_cnt > run_lo && run_cnt < run_hi) begin
      f.short_beep = 1'b1;
      run_cnt = '0;
    end else if (f.long_tone) begin
      // run count holds through a long tone
    end else if (f.short_tone) begin
      if (run_cnt != '1) run_cnt = run_cnt + 1'b1;
    end else begin
      run_cnt = '0;
    end
    return f;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tgt_a = TARGET_A_RST;
      tgt_b = TARGET_B_RST;
      wide = WIDE_MATCH_RST;
      long_min = LONG_MIN_RST;
      short_min = SHORT_MIN_RST;
      run_lo = RUN_LOW_RST;
      run_hi = RUN_HIGH_RST;
      hit_bits = '0;
      run_cnt = '0;
      flags_due.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.short_beep = short_beep;
        got.long_tone = long_tone;
        got.short_tone = short_tone;
        if (flags_due.size() == 0) begin
          if (errors < 10)
            $display("%0t: result with none pending: short_beep %0b long_tone %0b short_tone %0b",
                     $time, got.short_beep, got.long_tone, got.short_tone);
          errors++;
        end else begin
          want = flags_due.pop_front();
          if (got.short_beep !== want.short_beep || got.long_tone !== want.long_tone ||
              got.short_tone !== want.short_tone) begin
            if (errors < 10)
              $display({"%0t: mismatch (exp/got) short_beep %0b/%0b long_tone %0b/%0b",
                        " short_tone %0b/%0b"}, $time, want.short_beep, got.short_beep,
                       want.long_tone, got.long_tone, want.short_tone, got.short_tone);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) flags_due.push_back(qualify_frame(peak_bin));
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_A:  tgt_a = cfg_data[BIN_W-1:0];
          REG_TARGET_B:  tgt_b = cfg_data[BIN_W-1:0];
          REG_WIDE:      wide = cfg_data[0];
          REG_LONG_MIN:  long_min = cfg_data[THR_W-1:0];
          REG_SHORT_MIN: short_min = cfg_data[THR_W-1:0];
          REG_RUN_LOW:   run_lo = cfg_data[RUN_W-1:0];
          REG_RUN_HIGH:  run_hi = cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end
    end
    pending = flags_due.size();
  end

endmodule

/* tb/beep_tone_hit_qualifier_test.sv */
module beep_tone_hit_qualifier_test;
  import btq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RAND_PHASES = 8;
  localparam int RAND_FRAMES = 1100;
  localparam int RUN_FRAMES = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BIN_W-1:0]      peak_bin = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  short_beep;
  logic                  long_tone;
  logic                  short_tone;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    pending;

  bit no_gap = 1'b0;
  bit rx_quiet = 1'b0;
  int hold_req = 0;

  beep_tone_hit_qualifier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .peak_bin(peak_bin),
    .out_valid(out_valid), .out_stall(out_stall),
    .short_beep(short_beep), .long_tone(long_tone), .short_tone(short_tone),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  btq_tone_check tone_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .peak_bin(peak_bin),
    .out_valid(out_valid), .out_stall(out_stall),
    .short_beep(short_beep), .long_tone(long_tone), .short_tone(short_tone),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin : watchdog
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // random junk above the register width, which the block must drop
  function automatic logic [CFG_DATA_W-1:0] pad(int w, logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] j;
    j = CFG_DATA_W'($urandom);
    return (j << w) | v;
  endfunction

  function automatic logic [BIN_W-1:0] pick_bin();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return BIN_W'(1);
      3: return BIN_W'(1022);
      default: return BIN_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [BIN_W-1:0] tone_bin(logic [BIN_W-1:0] a, logic [BIN_W-1:0] b);
    logic [BIN_W-1:0] t;
    t = $urandom_range(0, 1) ? a : b;
    case ($urandom_range(0, 2))
      0: return t;
      1: return t + 1'b1;
      default: return t - 1'b1;
    endcase
  endfunction

  task automatic put_frame(input logic [BIN_W-1:0] bin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    peak_bin <= bin;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering items and wait for every pending result
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] b,
                          input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] lmin,
                          input logic [CFG_DATA_W-1:0] smin, input logic [CFG_DATA_W-1:0] lo,
                          input logic [CFG_DATA_W-1:0] hi);
    write_reg(REG_TARGET_A, a);
    write_reg(REG_TARGET_B, b);
    write_reg(REG_WIDE, w);
    write_reg(REG_LONG_MIN, lmin);
    write_reg(REG_SHORT_MIN, smin);
    write_reg(REG_RUN_LOW, lo);
    write_reg(REG_RUN_HIGH, hi);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        out_stall <= 1'b0;
      end else if (hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (rx_quiet || $urandom_range(0, 99) >= 20) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        case ($urandom_range(0, 19))
          0: repeat ($urandom_range(20, 60)) @(posedge clk);
          1, 2, 3, 4, 5: repeat ($urandom_range(4, 12)) @(posedge clk);
          default: repeat ($urandom_range(1, 3)) @(posedge clk);
        endcase
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int               sent;
    int               tone_left;
    int               quiet_left;
    int               per_phase;
    logic [BIN_W-1:0] ta;
    logic [BIN_W-1:0] tb;
    logic [BIN_W-1:0] bin;
    logic [THR_W-1:0] lmin;
    logic [THR_W-1:0] smin;
    logic [RUN_W-1:0] lo;
    logic [RUN_W-1:0] hi;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values: exact and adjacent target bins, range ends
    put_frame(117); put_frame(116); put_frame(118); put_frame(243);
    put_frame(242); put_frame(244); put_frame(115); put_frame(245);
    put_frame(0); put_frame(1023);
    settle();

    // target 0 must not match 1023; long threshold zero, short above history
    set_regs(0, 600, 1, 0, 33, 2, 3);
    put_frame(1023); put_frame(1); put_frame(0);
    settle();

    // target 1023 has 1022 as its only neighbor
    set_regs(1023, 1023, 1, 63, 0, 0, 65535);
    put_frame(0); put_frame(1022); put_frame(1023);
    settle();

    // exact matching only
    set_regs(117, 243, 0, 22, 2, 1, 35);
    put_frame(116); put_frame(117); put_frame(244); put_frame(243);
    settle();

    // short flag always set runs the count up frame after frame
    no_gap = 1'b1;
    rx_quiet = 1'b1;
    set_regs(117, 243, 1, 63, 0, 0, 65535);
    for (int i = 0; i < RUN_FRAMES; i++) put_frame(BIN_W'($urandom_range(0, 1023)));
    settle();
    // short flag drops with the count inside the limits: beep and clear
    set_regs(117, 243, 1, 63, 63, 0, 65535);
    put_frame(500); put_frame(500); put_frame(500);
    settle();

    per_phase = RAND_FRAMES / RAND_PHASES;
    tone_left = 0;
    quiet_left = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      ta = pick_bin();
      tb = ($urandom_range(0, 5) == 0) ? ta : pick_bin();
      case ($urandom_range(0, 7))
        0: lmin = 0;
        1: lmin = 32;
        2: lmin = 33;
        3: lmin = 63;
        default: lmin = THR_W'($urandom_range(8, 32));
      endcase
      case ($urandom_range(0, 7))
        0: smin = 0;
        1: smin = 32;
        2: smin = 40;
        default: smin = THR_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0: lo = 0;
        1: lo = '1;
        2: lo = RUN_W'($urandom);
        default: lo = RUN_W'($urandom_range(0, 4));
      endcase
      case ($urandom_range(0, 7))
        0: hi = 0;
        1: hi = '1;
        2: hi = lo + 1'b1;
        3: hi = RUN_W'($urandom);
        default: hi = lo + RUN_W'($urandom_range(2, 40));
      endcase
      set_regs(pad(BIN_W, CFG_DATA_W'(ta)), pad(BIN_W, CFG_DATA_W'(tb)),
               pad(1, CFG_DATA_W'($urandom_range(0, 1))),
               pad(THR_W, CFG_DATA_W'(lmin)), pad(THR_W, CFG_DATA_W'(smin)), lo, hi);
      no_gap = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < per_phase) begin
        // long hold-off with the sender pushing, so the input stalls
        if (p == 2 && sent == 20) begin
          rx_quiet = 1'b0;
          no_gap = 1'b1;
          hold_req = 120;
        end
        if (tone_left == 0 && quiet_left == 0) begin
          tone_left = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 14) : 0;
          quiet_left = $urandom_range(1, 30);
        end
        if (tone_left > 0) begin
          bin = tone_bin(ta, tb);
          tone_left--;
        end else begin
          bin = BIN_W'($urandom_range(0, 1023));
          quiet_left--;
        end
        put_frame(bin);
        sent++;
      end
      settle();
    end

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
